@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by the RTL of the skinning core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define QSE_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is high
`define QSE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

@@ rtl/core/qse_pkg.sv @@
// ----------------------------------------------------------------------------
// qse_pkg
// Shared widths, item codes and memory word layouts of the skinning core.
// ----------------------------------------------------------------------------
package qse_pkg;

   // Item kinds carried in the mode field
   localparam logic [1:0] MODE_JOINT  = 2'd0;
   localparam logic [1:0] MODE_WEIGHT = 2'd1;
   localparam logic [1:0] MODE_VERTEX = 2'd2;

   // Field widths
   localparam int POS_W   = 32;   // Q16.16
   localparam int QN_W    = 18;   // Q2.16
   localparam int BIAS_W  = 17;   // unsigned Q1.16, up to 1.0
   localparam int JREF_W  = 8;
   localparam int SLOT_W  = 12;
   localparam int COUNT_W = 5;

   // Datapath widths of the shared dot-product unit
   localparam int OPA_W  = 40;    // rotated values, joint pos + offset
   localparam int OPB_W  = 18;    // quaternion parts, bias
   localparam int PROD_W = OPA_W + OPB_W;
   localparam int SUM_W  = PROD_W + 3;
   localparam int ACC_W  = 64;

   localparam logic [BIAS_W-1:0] BIAS_ONE = 17'd65536;

   typedef struct packed {
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      logic [POS_W-1:0] pos_z;
      logic [QN_W-1:0]  rot_x;
      logic [QN_W-1:0]  rot_y;
      logic [QN_W-1:0]  rot_z;
      logic [QN_W-1:0]  rot_w;
   } joint_word_type;

   typedef struct packed {
      logic [JREF_W-1:0] joint;
      logic [BIAS_W-1:0] bias;
      logic [POS_W-1:0]  off_x;
      logic [POS_W-1:0]  off_y;
      logic [POS_W-1:0]  off_z;
      logic [QN_W-1:0]   nrm_x;
      logic [QN_W-1:0]   nrm_y;
      logic [QN_W-1:0]   nrm_z;
   } weight_word_type;

endpackage

@@ rtl/core/qse_req_if.sv @@
// ----------------------------------------------------------------------------
// qse_req_if
// Request channel: joint writes, weight writes and vertex skinning requests.
// ----------------------------------------------------------------------------
interface qse_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         mode;
   logic [11:0]        slot;
   logic [7:0]         joint_ref;
   logic [16:0]        bias;
   logic signed [31:0] vec_a_x;
   logic signed [31:0] vec_a_y;
   logic signed [31:0] vec_a_z;
   logic signed [17:0] vec_b_x;
   logic signed [17:0] vec_b_y;
   logic signed [17:0] vec_b_z;
   logic signed [17:0] quat_w;
   logic [4:0]         weight_count;

   modport source (
      output valid, mode, slot, joint_ref, bias, vec_a_x, vec_a_y, vec_a_z,
             vec_b_x, vec_b_y, vec_b_z, quat_w, weight_count,
      input  ready
   );
   modport sink (
      input  valid, mode, slot, joint_ref, bias, vec_a_x, vec_a_y, vec_a_z,
             vec_b_x, vec_b_y, vec_b_z, quat_w, weight_count,
      output ready
   );
endinterface

@@ rtl/core/qse_rsp_if.sv @@
// ----------------------------------------------------------------------------
// qse_rsp_if
// Response channel: skinned position and blended normal of one vertex.
// ----------------------------------------------------------------------------
interface qse_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] skinned_x;
   logic signed [31:0] skinned_y;
   logic signed [31:0] skinned_z;
   logic signed [17:0] normal_x;
   logic signed [17:0] normal_y;
   logic signed [17:0] normal_z;

   modport source (
      output valid, skinned_x, skinned_y, skinned_z, normal_x, normal_y, normal_z,
      input  ready
   );
   modport sink (
      input  valid, skinned_x, skinned_y, skinned_z, normal_x, normal_y, normal_z,
      output ready
   );
endinterface

@@ rtl/core/quaternion_skinning_engine_core.sv @@
// ----------------------------------------------------------------------------
// quaternion_skinning_engine_core
// Quaternion linear blend skinning over a joint memory and a weight memory.
// ----------------------------------------------------------------------------
// Joint and weight writes keep the sequencer idle, so requests can follow them back to back.
// A vertex with n in-range weights (after clipping) is worked weight by weight: per weight
// a weight read, a joint read, the issue slots of the one 4-term dot-product unit and a drain
// step; the response is then loaded once the output register is free.
// A weight index beyond the table is skipped and adds nothing. One vertex in flight; requests are taken
// while a response waits. Sync active-high reset clears control state; memories are not.
`include "assert_macros.svh"

module quaternion_skinning_engine_core #(
   parameter int JOINT_DEPTH            = 256,
   parameter int WEIGHT_DEPTH           = 4096,
   parameter int MAX_WEIGHTS_PER_VERTEX = 16
) (
   input  logic       clock,
   input  logic       reset,
   qse_req_if.sink    req_ch,
   qse_rsp_if.source  rsp_ch
);

   localparam int JA   = (JOINT_DEPTH > 1) ? $clog2(JOINT_DEPTH) : 1;
   localparam int WA   = $clog2(WEIGHT_DEPTH);
   localparam int WI_W = ((WA > qse_pkg::SLOT_W) ? WA : qse_pkg::SLOT_W) + 1;
   localparam int CW   = $clog2(MAX_WEIGHTS_PER_VERTEX + 1);
   localparam int AW   = qse_pkg::OPA_W;
   localparam int SW   = qse_pkg::SUM_W;
   localparam int CCW  = qse_pkg::ACC_W;

   // Issue schedule of one weight
   localparam logic [4:0] STEP_TP   = 5'd0;   // t for offset: w,x,y,z
   localparam logic [4:0] STEP_TN   = 5'd4;   // t for normal
   localparam logic [4:0] STEP_RP   = 5'd8;   // r for offset: x,y,z
   localparam logic [4:0] STEP_RN   = 5'd11;  // r for normal
   localparam logic [4:0] STEP_BP   = 5'd14;  // bias * (joint pos + r)
   localparam logic [4:0] STEP_BN   = 5'd17;  // bias * r normal
   localparam logic [4:0] STEP_LAST = 5'd20;

   localparam logic signed [SW-1:0]  RND_SUM = SW'(32768);
   localparam logic signed [CCW-1:0] RND_ACC = CCW'(32768);
   localparam logic signed [CCW-1:0] P_MAX   = CCW'(64'sh7FFF_FFFF);
   localparam logic signed [CCW-1:0] P_MIN   = -P_MAX - CCW'(1);
   localparam logic signed [CCW-1:0] N_MAX   = CCW'(64'sh1_FFFF);
   localparam logic signed [CCW-1:0] N_MIN   = -N_MAX - CCW'(1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_NEXT, ST_WRD, ST_JRD, ST_CALC, ST_FIN
   } state_type;

   typedef struct packed {
      logic       valid;
      logic [4:0] step;
   } op_type;

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   state_type                    state_ff, state_in;
   logic [4:0]                   step_ff, step_in;
   logic [WI_W-1:0]              widx_ff, widx_in;
   logic [CW-1:0]                left_ff, left_in;
   logic                         jvalid_ff, jvalid_in;
   op_type                       op_ff, op_in;
   logic signed [AW-1:0]         t_ff [2][4];
   logic signed [AW-1:0]         t_in [2][4];
   logic signed [AW-1:0]         r_ff [2][3];
   logic signed [AW-1:0]         r_in [2][3];
   logic signed [CCW-1:0]        accp_ff [3];
   logic signed [CCW-1:0]        accp_in [3];
   logic signed [CCW-1:0]        accn_ff [3];
   logic signed [CCW-1:0]        accn_in [3];
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]           rsp_p_ff [3];
   logic signed [31:0]           rsp_p_in [3];
   logic signed [17:0]           rsp_n_ff [3];
   logic signed [17:0]           rsp_n_in [3];
   logic signed [qse_pkg::PROD_W-1:0] prod_ff [4];

   // Memories
   qse_pkg::joint_word_type  jmem [JOINT_DEPTH];
   qse_pkg::weight_word_type wmem [WEIGHT_DEPTH];
   qse_pkg::joint_word_type  j_rd_ff;
   qse_pkg::weight_word_type w_rd_ff;

   logic                     req_take;
   logic                     vertex_take;
   logic                     fin_load;
   logic                     j_wen, w_wen, w_ren, j_ren;
   qse_pkg::joint_word_type  j_wdata;
   qse_pkg::weight_word_type w_wdata;
   logic [JA-1:0]            j_raddr;
   logic [WA-1:0]            w_raddr;
   logic [qse_pkg::BIAS_W-1:0] bias_clip;

   logic signed [AW-1:0]     opa [4];
   logic signed [17:0]       opb [4];
   logic signed [17:0]       qx, qy, qz, qw;
   logic signed [AW-1:0]     vx, vy, vz;
   logic signed [AW-1:0]     jp [3];
   logic signed [17:0]       bias_s;
   logic                     side;
   logic [4:0]               rel;
   logic signed [SW-1:0]     sum, sum_rnd;
   logic signed [AW-1:0]     res_rnd;
   logic [4:0]               wb_rel;
   logic signed [CCW-1:0]    acc_tmp, acc_sh;
   logic [CW-1:0]            cnt_eff;

   assign req_take     = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign vertex_take  = req_take && (req_ch.mode == qse_pkg::MODE_VERTEX);
   assign fin_load     = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ch.ready);

   // ------------------------------------------------------------------
   // Table writes from request transactions
   // ------------------------------------------------------------------
   always_comb begin
      bias_clip = (req_ch.bias > qse_pkg::BIAS_ONE) ? qse_pkg::BIAS_ONE : req_ch.bias;
      j_wen = req_take && (req_ch.mode == qse_pkg::MODE_JOINT) &&
              (32'(req_ch.slot) < JOINT_DEPTH);
      w_wen = req_take && (req_ch.mode == qse_pkg::MODE_WEIGHT) &&
              (32'(req_ch.slot) < WEIGHT_DEPTH);
      j_wdata = '{pos_x: req_ch.vec_a_x, pos_y: req_ch.vec_a_y, pos_z: req_ch.vec_a_z,
                  rot_x: req_ch.vec_b_x, rot_y: req_ch.vec_b_y, rot_z: req_ch.vec_b_z,
                  rot_w: req_ch.quat_w};
      w_wdata = '{joint: req_ch.joint_ref, bias: bias_clip,
                  off_x: req_ch.vec_a_x, off_y: req_ch.vec_a_y, off_z: req_ch.vec_a_z,
                  nrm_x: req_ch.vec_b_x, nrm_y: req_ch.vec_b_y, nrm_z: req_ch.vec_b_z};
   end

   // Joint memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (j_wen) begin
         jmem[JA'(req_ch.slot)] <= j_wdata;
      end
      if (j_ren) begin
         j_rd_ff <= jmem[j_raddr];
      end
   end

   // Weight memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (w_wen) begin
         wmem[WA'(req_ch.slot)] <= w_wdata;
      end
      if (w_ren) begin
         w_rd_ff <= wmem[w_raddr];
      end
   end

   // ------------------------------------------------------------------
   // Operand select for the dot-product unit
   // ------------------------------------------------------------------
   always_comb begin
      qx = jvalid_ff ? $signed(j_rd_ff.rot_x) : '0;
      qy = jvalid_ff ? $signed(j_rd_ff.rot_y) : '0;
      qz = jvalid_ff ? $signed(j_rd_ff.rot_z) : '0;
      qw = jvalid_ff ? $signed(j_rd_ff.rot_w) : '0;
      jp[0] = jvalid_ff ? AW'($signed(j_rd_ff.pos_x)) : '0;
      jp[1] = jvalid_ff ? AW'($signed(j_rd_ff.pos_y)) : '0;
      jp[2] = jvalid_ff ? AW'($signed(j_rd_ff.pos_z)) : '0;
      bias_s = $signed({1'b0, w_rd_ff.bias});

      if (step_ff < STEP_TN) begin
         vx = AW'($signed(w_rd_ff.off_x));
         vy = AW'($signed(w_rd_ff.off_y));
         vz = AW'($signed(w_rd_ff.off_z));
      end else begin
         vx = AW'($signed(w_rd_ff.nrm_x));
         vy = AW'($signed(w_rd_ff.nrm_y));
         vz = AW'($signed(w_rd_ff.nrm_z));
      end

      side = 1'b0;
      rel  = '0;
      for (int i = 0; i < 4; i++) begin
         opa[i] = '0;
         opb[i] = '0;
      end

      if (step_ff < STEP_RP) begin
         // t = q * (v,0); signs ride on the wide operand
         case (step_ff[1:0])
            2'd0: begin
               opa[0] = -vx; opa[1] = -vy; opa[2] = -vz;
               opb[0] = qx;  opb[1] = qy;  opb[2] = qz;
            end
            2'd1: begin
               opa[0] = vx; opa[1] = vz; opa[2] = -vy;
               opb[0] = qw; opb[1] = qy; opb[2] = qz;
            end
            2'd2: begin
               opa[0] = vy; opa[1] = vx; opa[2] = -vz;
               opb[0] = qw; opb[1] = qz; opb[2] = qx;
            end
            default: begin
               opa[0] = vz; opa[1] = vy; opa[2] = -vx;
               opb[0] = qw; opb[1] = qx; opb[2] = qy;
            end
         endcase
      end else if (step_ff < STEP_BP) begin
         // r = t * conj(q)
         side = (step_ff >= STEP_RN);
         rel  = step_ff - (side ? STEP_RN : STEP_RP);
         case (rel[1:0])
            2'd0: begin
               opa[0] = t_ff[side][1]; opa[1] = -t_ff[side][0];
               opa[2] = -t_ff[side][2]; opa[3] = t_ff[side][3];
               opb[0] = qw; opb[1] = qx; opb[2] = qz; opb[3] = qy;
            end
            2'd1: begin
               opa[0] = t_ff[side][2]; opa[1] = -t_ff[side][0];
               opa[2] = -t_ff[side][3]; opa[3] = t_ff[side][1];
               opb[0] = qw; opb[1] = qy; opb[2] = qx; opb[3] = qz;
            end
            default: begin
               opa[0] = t_ff[side][3]; opa[1] = -t_ff[side][0];
               opa[2] = -t_ff[side][1]; opa[3] = t_ff[side][2];
               opb[0] = qw; opb[1] = qz; opb[2] = qy; opb[3] = qx;
            end
         endcase
      end else begin
         // bias products, summed without rounding
         side = (step_ff >= STEP_BN);
         rel  = step_ff - (side ? STEP_BN : STEP_BP);
         case (rel[1:0])
            2'd0:    opa[0] = side ? r_ff[1][0] : (jp[0] + r_ff[0][0]);
            2'd1:    opa[0] = side ? r_ff[1][1] : (jp[1] + r_ff[0][1]);
            default: opa[0] = side ? r_ff[1][2] : (jp[2] + r_ff[0][2]);
         endcase
         opb[0] = bias_s;
      end
   end

   // Multiplier stage of the dot-product unit
   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         prod_ff[i] <= opa[i] * opb[i];
      end
   end

   // Adder stage and rounding
   always_comb begin
      sum = SW'(prod_ff[0]) + SW'(prod_ff[1]) + SW'(prod_ff[2]) + SW'(prod_ff[3]);
      sum_rnd = sum + RND_SUM;
      res_rnd = AW'(sum_rnd >>> 16);
   end

   // ------------------------------------------------------------------
   // Sequencer next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      widx_in      = widx_ff;
      left_in      = left_ff;
      jvalid_in    = jvalid_ff;
      op_in        = '{valid: 1'b0, step: step_ff};
      t_in         = t_ff;
      r_in         = r_ff;
      accp_in      = accp_ff;
      accn_in      = accn_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_p_in     = rsp_p_ff;
      rsp_n_in     = rsp_n_ff;
      w_ren        = 1'b0;
      j_ren        = 1'b0;
      w_raddr      = WA'(widx_ff);
      j_raddr      = JA'(w_rd_ff.joint);
      wb_rel       = '0;
      acc_tmp      = '0;
      acc_sh       = '0;
      cnt_eff = (32'(req_ch.weight_count) > MAX_WEIGHTS_PER_VERTEX) ?
                CW'(MAX_WEIGHTS_PER_VERTEX) : CW'(req_ch.weight_count);

      // write back the result of an issued op once its products sit in prod_ff, tagged by op_ff
      if (op_ff.valid) begin
         if (op_ff.step < STEP_RP) begin
            t_in[op_ff.step >= STEP_TN][op_ff.step[1:0]] = res_rnd;
         end else if (op_ff.step < STEP_RN) begin
            wb_rel = op_ff.step - STEP_RP;
            r_in[0][wb_rel[1:0]] = res_rnd;
         end else if (op_ff.step < STEP_BP) begin
            wb_rel = op_ff.step - STEP_RN;
            r_in[1][wb_rel[1:0]] = res_rnd;
         end else if (op_ff.step < STEP_BN) begin
            wb_rel = op_ff.step - STEP_BP;
            accp_in[wb_rel[1:0]] = accp_ff[wb_rel[1:0]] + CCW'(sum);
         end else begin
            wb_rel = op_ff.step - STEP_BN;
            accn_in[wb_rel[1:0]] = accn_ff[wb_rel[1:0]] + CCW'(sum);
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && req_ch.mode == qse_pkg::MODE_VERTEX) begin
               widx_in = WI_W'(req_ch.slot);
               left_in = cnt_eff;
               for (int k = 0; k < 3; k++) begin
                  accp_in[k] = '0;
                  accn_in[k] = '0;
               end
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (left_ff == '0) begin
               state_in = ST_FIN;
            end else if (32'(widx_ff) >= WEIGHT_DEPTH) begin
               // weight beyond the table adds nothing
               left_in = left_ff - CW'(1);
               widx_in = widx_ff + WI_W'(1);
            end else begin
               w_ren    = 1'b1;
               state_in = ST_WRD;
            end
         end
         ST_WRD: begin
            j_ren     = 1'b1;
            jvalid_in = (32'(w_rd_ff.joint) < JOINT_DEPTH);
            state_in  = ST_JRD;
         end
         ST_JRD: begin
            step_in  = STEP_TP;
            state_in = ST_CALC;
         end
         ST_CALC: begin
            op_in = '{valid: (step_ff < STEP_LAST), step: step_ff};
            if (step_ff == STEP_LAST) begin
               left_in  = left_ff - CW'(1);
               widx_in  = widx_ff + WI_W'(1);
               state_in = ST_NEXT;
            end else begin
               step_in = step_ff + 5'd1;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               for (int k = 0; k < 3; k++) begin
                  acc_tmp = accp_ff[k] + RND_ACC;
                  acc_sh  = acc_tmp >>> 16;
                  rsp_p_in[k] = (acc_sh > P_MAX) ? 32'(P_MAX) :
                                (acc_sh < P_MIN) ? 32'(P_MIN) : 32'(acc_sh);
                  acc_tmp = accn_ff[k] + RND_ACC;
                  acc_sh  = acc_tmp >>> 16;
                  rsp_n_in[k] = (acc_sh > N_MAX) ? 18'(N_MAX) :
                                (acc_sh < N_MIN) ? 18'(N_MIN) : 18'(acc_sh);
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // Sequencer registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         left_ff      <= '0;
         op_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         left_ff      <= left_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      widx_ff   <= widx_in;
      jvalid_ff <= jvalid_in;
      t_ff      <= t_in;
      r_ff      <= r_in;
      accp_ff   <= accp_in;
      accn_ff   <= accn_in;
      rsp_p_ff  <= rsp_p_in;
      rsp_n_ff  <= rsp_n_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.skinned_x = rsp_p_ff[0];
   assign rsp_ch.skinned_y = rsp_p_ff[1];
   assign rsp_ch.skinned_z = rsp_p_ff[2];
   assign rsp_ch.normal_x  = rsp_n_ff[0];
   assign rsp_ch.normal_y  = rsp_n_ff[1];
   assign rsp_ch.normal_z  = rsp_n_ff[2];

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `QSE_ASSERT_NOW(a_op_in_calc, clock, reset, op_ff.valid, state_ff == ST_CALC)
   `QSE_ASSERT_NOW(a_left_bound, clock, reset, 1'b1, 32'(left_ff) <= MAX_WEIGHTS_PER_VERTEX)
   `QSE_ASSERT_NEXT(a_vertex_start, clock, reset, vertex_take, state_ff == ST_NEXT)
   `QSE_ASSERT_NEXT(a_fin_loads, clock, reset, fin_load, rsp_valid_ff && state_ff == ST_IDLE)

endmodule

@@ tb/tb_quaternion_skinning_engine_core.sv @@
// ----------------------------------------------------------------------------
// tb_quaternion_skinning_engine_core
// Self-checking bench for the quaternion skinning core. Joint and weight
// tables are loaded through the request channel and vertices are skinned.
// A local fixed-point predictor produces the expected position and normal
// for every vertex. The monitor checks each response field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_quaternion_skinning_engine_core;

   localparam int JOINT_ENTRIES  = 256;
   localparam int WEIGHT_ENTRIES = 4096;
   localparam int MAX_WPV        = 16;
   localparam int RANDOM_ITEMS   = 900;
   localparam int CALM_TAIL      = 120;   // last items run without idling

   // Mode code with no operation behind it
   localparam logic [1:0] MODE_RESERVED = 2'd3;

   typedef struct packed {
      logic [1:0]         mode;
      logic [11:0]        slot;
      logic [7:0]         joint_ref;
      logic [16:0]        bias;
      logic signed [31:0] vec_a_x;
      logic signed [31:0] vec_a_y;
      logic signed [31:0] vec_a_z;
      logic signed [17:0] vec_b_x;
      logic signed [17:0] vec_b_y;
      logic signed [17:0] vec_b_z;
      logic signed [17:0] quat_w;
      logic [4:0]         weight_count;
   } skin_req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [17:0] nrm_x;
      logic signed [17:0] nrm_y;
      logic signed [17:0] nrm_z;
   } skinned_vertex_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   qse_req_if req_ch ();
   qse_rsp_if rsp_ch ();

   quaternion_skinning_engine_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   // Stimulus queue, expected vertex queue, error count
   skin_req_type       pending_reqs[$];
   skinned_vertex_type expected_vertices[$];
   int                 mismatch_count = 0;

   // Predictor copy of the tables
   qse_pkg::joint_word_type  joint_table[JOINT_ENTRIES];
   qse_pkg::weight_word_type weight_table[WEIGHT_ENTRIES];

   // Generation-time record of which entries hold data
   bit joint_loaded[JOINT_ENTRIES];
   bit weight_loaded[WEIGHT_ENTRIES];

   // ------------------------------------------------------------------
   // Fixed-point helpers
   // ------------------------------------------------------------------
   function automatic longint round_q16(longint x);
      return (x + 64'sd32768) >>> 16;
   endfunction

   function automatic longint clamp_signed(longint v, int w);
      longint hi;
      longint lo;
      hi = (64'sd1 <<< (w - 1)) - 1;
      lo = -hi - 1;
      return (v > hi) ? hi : ((v < lo) ? lo : v);
   endfunction

   // q * (v,0) * conj(q), rounded after each product stage
   task automatic quat_rotate(input longint q[4], input longint v[3],
                              output longint r[3]);
      longint tw, tx, ty, tz;
      tw = round_q16(-q[0] * v[0] - q[1] * v[1] - q[2] * v[2]);
      tx = round_q16(q[3] * v[0] + q[1] * v[2] - q[2] * v[1]);
      ty = round_q16(q[3] * v[1] + q[2] * v[0] - q[0] * v[2]);
      tz = round_q16(q[3] * v[2] + q[0] * v[1] - q[1] * v[0]);
      r[0] = round_q16(tx * q[3] - tw * q[0] - ty * q[2] + tz * q[1]);
      r[1] = round_q16(ty * q[3] - tw * q[1] - tz * q[0] + tx * q[2]);
      r[2] = round_q16(tz * q[3] - tw * q[2] - tx * q[1] + ty * q[0]);
   endtask

   // Apply one accepted transaction to the predictor
   task automatic predict_skinning(input skin_req_type t);
      int unsigned              n;
      int unsigned              wi;
      longint                   acc_p[3];
      longint                   acc_n[3];
      longint                   q[4];
      longint                   jp[3];
      longint                   off[3];
      longint                   nv[3];
      longint                   rp[3];
      longint                   rn[3];
      longint                   b;
      qse_pkg::joint_word_type  jw;
      qse_pkg::weight_word_type ww;
      skinned_vertex_type       res;
      case (t.mode)
         qse_pkg::MODE_JOINT: begin
            if (t.slot < JOINT_ENTRIES) begin
               jw.pos_x = t.vec_a_x;
               jw.pos_y = t.vec_a_y;
               jw.pos_z = t.vec_a_z;
               jw.rot_x = t.vec_b_x;
               jw.rot_y = t.vec_b_y;
               jw.rot_z = t.vec_b_z;
               jw.rot_w = t.quat_w;
               joint_table[8'(t.slot)] = jw;
            end
         end
         qse_pkg::MODE_WEIGHT: begin
            ww.joint = t.joint_ref;
            ww.bias  = (t.bias > qse_pkg::BIAS_ONE) ? qse_pkg::BIAS_ONE : t.bias;
            ww.off_x = t.vec_a_x;
            ww.off_y = t.vec_a_y;
            ww.off_z = t.vec_a_z;
            ww.nrm_x = t.vec_b_x;
            ww.nrm_y = t.vec_b_y;
            ww.nrm_z = t.vec_b_z;
            weight_table[t.slot] = ww;
         end
         qse_pkg::MODE_VERTEX: begin
            n = (t.weight_count > MAX_WPV) ? MAX_WPV : t.weight_count;
            for (int k = 0; k < 3; k++) begin
               acc_p[k] = 0;
               acc_n[k] = 0;
            end
            for (int j = 0; j < n; j++) begin
               wi = t.slot + j;
               if (wi < WEIGHT_ENTRIES) begin
                  ww = weight_table[12'(wi)];
                  jw = joint_table[ww.joint];
                  b  = longint'(ww.bias);
                  jp[0] = longint'(signed'(jw.pos_x));
                  jp[1] = longint'(signed'(jw.pos_y));
                  jp[2] = longint'(signed'(jw.pos_z));
                  q[0]  = longint'(signed'(jw.rot_x));
                  q[1]  = longint'(signed'(jw.rot_y));
                  q[2]  = longint'(signed'(jw.rot_z));
                  q[3]  = longint'(signed'(jw.rot_w));
                  off[0] = longint'(signed'(ww.off_x));
                  off[1] = longint'(signed'(ww.off_y));
                  off[2] = longint'(signed'(ww.off_z));
                  nv[0]  = longint'(signed'(ww.nrm_x));
                  nv[1]  = longint'(signed'(ww.nrm_y));
                  nv[2]  = longint'(signed'(ww.nrm_z));
                  quat_rotate(q, off, rp);
                  quat_rotate(q, nv, rn);
                  for (int k = 0; k < 3; k++) begin
                     acc_p[k] += (jp[k] + rp[k]) * b;
                     acc_n[k] += rn[k] * b;
                  end
               end
            end
            res.pos_x = 32'(clamp_signed(round_q16(acc_p[0]), qse_pkg::POS_W));
            res.pos_y = 32'(clamp_signed(round_q16(acc_p[1]), qse_pkg::POS_W));
            res.pos_z = 32'(clamp_signed(round_q16(acc_p[2]), qse_pkg::POS_W));
            res.nrm_x = 18'(clamp_signed(round_q16(acc_n[0]), qse_pkg::QN_W));
            res.nrm_y = 18'(clamp_signed(round_q16(acc_n[1]), qse_pkg::QN_W));
            res.nrm_z = 18'(clamp_signed(round_q16(acc_n[2]), qse_pkg::QN_W));
            expected_vertices.push_back(res);
         end
         default: ;
      endcase
   endtask

   // ------------------------------------------------------------------
   // Stimulus construction
   // ------------------------------------------------------------------
   function automatic skin_req_type random_fields();
      skin_req_type t;
      t.mode         = 2'($urandom_range(0, 3));
      t.slot         = 12'($urandom);
      t.joint_ref    = 8'($urandom);
      t.bias         = 17'($urandom);
      t.vec_a_x      = $urandom;
      t.vec_a_y      = $urandom;
      t.vec_a_z      = $urandom;
      t.vec_b_x      = 18'($urandom);
      t.vec_b_y      = 18'($urandom);
      t.vec_b_z      = 18'($urandom);
      t.quat_w       = 18'($urandom);
      t.weight_count = 5'($urandom);
      return t;
   endfunction

   // Positions: half small values, half full range
   function automatic logic signed [31:0] pick_pos();
      if ($urandom_range(0, 1))
         return $signed($urandom_range(0, 2097151)) - 32'sd1048576;
      return $urandom;
   endfunction

   // Quaternion/normal parts: identity-like, unit-scale or full range
   function automatic logic signed [17:0] pick_qn();
      case ($urandom_range(0, 3))
         0: return 18'sd65536;
         1: return 18'($signed($urandom_range(0, 131072)) - 32'sd65536);
         default: return 18'($urandom);
      endcase
   endfunction

   function automatic skin_req_type make_joint(int slot);
      skin_req_type t;
      t = random_fields();
      t.mode    = qse_pkg::MODE_JOINT;
      t.slot    = 12'(slot);
      t.vec_a_x = pick_pos();
      t.vec_a_y = pick_pos();
      t.vec_a_z = pick_pos();
      t.vec_b_x = pick_qn();
      t.vec_b_y = pick_qn();
      t.vec_b_z = pick_qn();
      t.quat_w  = pick_qn();
      if (slot < JOINT_ENTRIES)
         joint_loaded[8'(slot)] = 1'b1;
      return t;
   endfunction

   function automatic skin_req_type make_weight(int slot);
      skin_req_type t;
      int           jr;
      t = random_fields();
      t.mode = qse_pkg::MODE_WEIGHT;
      t.slot = 12'(slot);
      jr = $urandom_range(0, JOINT_ENTRIES - 1);
      for (int tries = 0; tries < 64 && !joint_loaded[8'(jr)]; tries++)
         jr = $urandom_range(0, JOINT_ENTRIES - 1);
      if (!joint_loaded[8'(jr)])
         jr = 0;
      t.joint_ref = 8'(jr);
      t.vec_a_x = pick_pos();
      t.vec_a_y = pick_pos();
      t.vec_a_z = pick_pos();
      t.vec_b_x = pick_qn();
      t.vec_b_y = pick_qn();
      t.vec_b_z = pick_qn();
      if ($urandom_range(0, 3) != 0)
         t.bias = 17'($urandom_range(0, 65536));
      weight_loaded[12'(slot)] = 1'b1;
      return t;
   endfunction

   function automatic skin_req_type make_vertex(int slot, int cnt);
      skin_req_type t;
      t = random_fields();
      t.mode         = qse_pkg::MODE_VERTEX;
      t.slot         = 12'(slot);
      t.weight_count = 5'(cnt);
      return t;
   endfunction

   // True when every weight the vertex walks holds data
   function automatic bit vertex_safe(int slot, int cnt);
      int n;
      n = (cnt > MAX_WPV) ? MAX_WPV : cnt;
      for (int j = 0; j < n; j++)
         if (slot + j < WEIGHT_ENTRIES && !weight_loaded[12'(slot + j)])
            return 1'b0;
      return 1'b1;
   endfunction

   // Weight slots in use: low block and the top end of the table
   function automatic int pick_weight_slot();
      if ($urandom_range(0, 1))
         return $urandom_range(0, 63);
      return $urandom_range(WEIGHT_ENTRIES - 32, WEIGHT_ENTRIES - 1);
   endfunction

   task automatic build_stimulus();
      skin_req_type t;
      int           s;
      int           c;
      bit           found;
      // Directed: joint extremes, ignored joint slots, unused mode
      t = make_joint(0);
      t.vec_b_x = '0; t.vec_b_y = '0; t.vec_b_z = '0; t.quat_w = 18'sd65536;
      pending_reqs.push_back(t);
      t = make_joint(255);
      t.vec_a_x = 32'sh7fffffff; t.vec_a_y = 32'sh80000000; t.vec_a_z = '0;
      t.vec_b_x = 18'sh1ffff; t.vec_b_y = 18'sh20000;
      t.vec_b_z = 18'sh1ffff; t.quat_w = 18'sh20000;
      pending_reqs.push_back(t);
      pending_reqs.push_back(make_joint(256));
      pending_reqs.push_back(make_joint(4095));
      t = random_fields();
      t.mode = MODE_RESERVED;
      pending_reqs.push_back(t);
      // Weights 0..15 and the two top slots, with bias extremes
      for (int i = 0; i < 16; i++) begin
         t = make_weight(i);
         if (i == 0) begin
            t.bias = qse_pkg::BIAS_ONE; t.joint_ref = '0;
         end else if (i == 1) begin
            t.bias = 17'h1ffff; t.joint_ref = 8'd255;
            t.vec_a_x = 32'sh80000000; t.vec_a_y = 32'sh7fffffff;
         end else if (i == 2) begin
            t.bias = '0;
         end
         pending_reqs.push_back(t);
      end
      pending_reqs.push_back(make_weight(WEIGHT_ENTRIES - 2));
      pending_reqs.push_back(make_weight(WEIGHT_ENTRIES - 1));
      // Vertices: zero count, plain, clipped count, walk past the table end
      pending_reqs.push_back(make_vertex(0, 0));
      pending_reqs.push_back(make_vertex(0, 2));
      pending_reqs.push_back(make_vertex(0, 31));
      pending_reqs.push_back(make_vertex(WEIGHT_ENTRIES - 2, 5));

      // Random part: mostly loads and well-formed vertices
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               if ($urandom_range(0, 3) == 0)
                  s = $urandom_range(0, 4095);
               else
                  s = $urandom_range(0, JOINT_ENTRIES - 1);
               pending_reqs.push_back(make_joint(s));
            end
            2, 3, 4: begin
               if ($urandom_range(0, 4) == 0)
                  s = $urandom_range(0, WEIGHT_ENTRIES - 1);
               else
                  s = pick_weight_slot();
               pending_reqs.push_back(make_weight(s));
            end
            5: begin
               t = random_fields();
               t.mode = MODE_RESERVED;
               pending_reqs.push_back(t);
            end
            default: begin
               found = 1'b0;
               for (int tries = 0; tries < 20 && !found; tries++) begin
                  s = pick_weight_slot();
                  c = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 31)
                                                  : $urandom_range(0, 16);
                  found = vertex_safe(s, c);
               end
               if (found)
                  pending_reqs.push_back(make_vertex(s, c));
               else
                  pending_reqs.push_back(make_weight(pick_weight_slot()));
            end
         endcase
      end
   endtask

   // ------------------------------------------------------------------
   // Request driver
   // ------------------------------------------------------------------
   int           req_idle_left = 0;
   skin_req_type cur_req;

   initial begin
      req_ch.valid        = 1'b0;
      req_ch.mode         = '0;
      req_ch.slot         = '0;
      req_ch.joint_ref    = '0;
      req_ch.bias         = '0;
      req_ch.vec_a_x      = '0;
      req_ch.vec_a_y      = '0;
      req_ch.vec_a_z      = '0;
      req_ch.vec_b_x      = '0;
      req_ch.vec_b_y      = '0;
      req_ch.vec_b_z      = '0;
      req_ch.quat_w       = '0;
      req_ch.weight_count = '0;
      rsp_ch.ready        = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         // A transaction completes: feed it to the predictor
         if (req_ch.valid && req_ch.ready)
            predict_skinning(cur_req);
         if (!req_ch.valid || req_ch.ready) begin
            if (req_idle_left > 0) begin
               req_idle_left <= req_idle_left - 1;
               req_ch.valid  <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               cur_req = pending_reqs.pop_front();
               req_ch.valid        <= 1'b1;
               req_ch.mode         <= cur_req.mode;
               req_ch.slot         <= cur_req.slot;
               req_ch.joint_ref    <= cur_req.joint_ref;
               req_ch.bias         <= cur_req.bias;
               req_ch.vec_a_x      <= cur_req.vec_a_x;
               req_ch.vec_a_y      <= cur_req.vec_a_y;
               req_ch.vec_a_z      <= cur_req.vec_a_z;
               req_ch.vec_b_x      <= cur_req.vec_b_x;
               req_ch.vec_b_y      <= cur_req.vec_b_y;
               req_ch.vec_b_z      <= cur_req.vec_b_z;
               req_ch.quat_w       <= cur_req.quat_w;
               req_ch.weight_count <= cur_req.weight_count;
               if (pending_reqs.size() > CALM_TAIL && $urandom_range(0, 3) == 0)
                  req_idle_left <= $urandom_range(1, 3);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Response monitor with random back-pressure
   // ------------------------------------------------------------------
   int                 rsp_stall_left = 0;
   skinned_vertex_type exp_v;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_vertices.size() == 0) begin
               $error("unexpected response transaction");
               mismatch_count++;
            end else begin
               exp_v = expected_vertices.pop_front();
               if (rsp_ch.skinned_x !== exp_v.pos_x) begin
                  $error("skinned_x expected %0d actual %0d",
                         exp_v.pos_x, rsp_ch.skinned_x);
                  mismatch_count++;
               end
               if (rsp_ch.skinned_y !== exp_v.pos_y) begin
                  $error("skinned_y expected %0d actual %0d",
                         exp_v.pos_y, rsp_ch.skinned_y);
                  mismatch_count++;
               end
               if (rsp_ch.skinned_z !== exp_v.pos_z) begin
                  $error("skinned_z expected %0d actual %0d",
                         exp_v.pos_z, rsp_ch.skinned_z);
                  mismatch_count++;
               end
               if (rsp_ch.normal_x !== exp_v.nrm_x) begin
                  $error("normal_x expected %0d actual %0d",
                         exp_v.nrm_x, rsp_ch.normal_x);
                  mismatch_count++;
               end
               if (rsp_ch.normal_y !== exp_v.nrm_y) begin
                  $error("normal_y expected %0d actual %0d",
                         exp_v.nrm_y, rsp_ch.normal_y);
                  mismatch_count++;
               end
               if (rsp_ch.normal_z !== exp_v.nrm_z) begin
                  $error("normal_z expected %0d actual %0d",
                         exp_v.nrm_z, rsp_ch.normal_z);
                  mismatch_count++;
               end
            end
         end
         // Stall bursts only while plenty of stimulus remains
         if (rsp_stall_left > 0) begin
            rsp_stall_left <= rsp_stall_left - 1;
            rsp_ch.ready   <= 1'b0;
         end else if (pending_reqs.size() > CALM_TAIL && $urandom_range(0, 3) == 0) begin
            rsp_stall_left <= $urandom_range(0, 2);
            rsp_ch.ready   <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Sequence and end of run
   // ------------------------------------------------------------------
   initial begin
      build_stimulus();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      wait (pending_reqs.size() == 0);
      @(posedge clock);
      while (req_ch.valid) @(posedge clock);
      while (expected_vertices.size() != 0) @(posedge clock);
      // Drain margin covering one full-length vertex
      repeat (500) @(posedge clock);
      if (mismatch_count == 0 && expected_vertices.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Watchdog
   initial begin
      #20ms;
      $display("Mismatches found");
      $finish;
   end

endmodule
